/* sv/protected_range_write_splitter_top_defines.svh */
`ifndef PROTECTED_RANGE_WRITE_SPLITTER_TOP_DEFINES_SVH
`define PROTECTED_RANGE_WRITE_SPLITTER_TOP_DEFINES_SVH

// Checks that hold in the same cycle and checks that look at the next cycle.
`define PRW_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define PRW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/prw_pkg.sv */
`default_nettype none

package prw_pkg;

   localparam int OFFSET_BITS    = 48;
   localparam int LENGTH_BITS    = 32;
   localparam int RANGE_COUNT    = 3;
   localparam int NUM_RANGES     = 3;
   localparam int RANK_BITS      = 2;
   localparam int RESULT_SLOTS   = RANGE_COUNT + 1;
   localparam int SLOT_BITS      = 2;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [LENGTH_BITS-1:0] length_type;

   typedef enum logic [1:0] {
      STATUS_SEGMENT   = 2'd0,
      STATUS_NONE      = 2'd1,
      STATUS_CANCELLED = 2'd2,
      STATUS_CAPACITY  = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEVICE_CAPACITY = 3'd0,
      CSR_RANGE0_BEGIN    = 3'd1,
      CSR_RANGE0_END      = 3'd2,
      CSR_RANGE1_BEGIN    = 3'd3,
      CSR_RANGE1_END      = 3'd4,
      CSR_RANGE2_BEGIN    = 3'd5,
      CSR_RANGE2_END      = 3'd6
   } csr_index_type;

   typedef struct packed {
      offset_type lo;
      offset_type hi;
   } range_type;

   typedef struct packed {
      offset_type seg_offset;
      length_type seg_length;
      length_type pay_offset;
      status_type status;
   } result_type;

endpackage

`default_nettype wire

/* sv/protected_range_write_splitter_top.sv */
// Channel  | Direction | Handshake            | Payload
// req_     | in        | req_valid/req_ready  | write_offset, write_length, cancel_requested
// rsp_     | out       | rsp_valid/rsp_ready  | segment_offset/length, data_offset, status, last
// csr_     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// A request beat passes three register stages and is then loaded into the result buffer,
// when its first result beat is presented at once. One result beat leaves per cycle while
// rsp_ready is high; a request yields one to four results at the output, and the next
// request is taken while the buffer drains.
// Reset is synchronous and active high; it clears all stage flags and the
// configuration registers. No clearing pass is needed. csr_ready is always high.
`default_nettype none

`include "protected_range_write_splitter_top_defines.svh"

module protected_range_write_splitter_top (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  prw_pkg::offset_type            req_write_offset,
   input  wire  prw_pkg::length_type            req_write_length,
   input  wire                                  req_cancel_requested,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output prw_pkg::offset_type                  rsp_segment_offset,
   output prw_pkg::length_type                  rsp_segment_length,
   output prw_pkg::length_type                  rsp_data_offset,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_last_result,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [prw_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  prw_pkg::offset_type            csr_wdata
);
   import prw_pkg::*;

   offset_type  cap_ff, cap_in;
   range_type   range_ff [RANGE_COUNT];
   range_type   range_in [RANGE_COUNT];

   logic        s1_valid_ff, s1_valid_in;
   offset_type  s1_offset_ff, s1_offset_in;
   length_type  s1_length_ff, s1_length_in;
   logic        s1_cancel_ff, s1_cancel_in;

   logic        s2_valid_ff, s2_valid_in;
   status_type  s2_status_ff, s2_status_in;
   offset_type  s2_offset_ff, s2_offset_in;
   offset_type  s2_wend_ff, s2_wend_in;
   range_type   s2_range_ff [RANGE_COUNT];
   range_type   s2_range_in [RANGE_COUNT];
   logic        s2_live_ff [RANGE_COUNT];
   logic        s2_live_in [RANGE_COUNT];

   logic        s3_valid_ff, s3_valid_in;
   status_type  s3_status_ff, s3_status_in;
   offset_type  s3_offset_ff, s3_offset_in;
   offset_type  s3_wend_ff, s3_wend_in;
   offset_type  s3_lo_ff [RANGE_COUNT];
   offset_type  s3_lo_in [RANGE_COUNT];
   logic        s3_use_ff [RANGE_COUNT];
   logic        s3_use_in [RANGE_COUNT];
   offset_type  s3_cur_ff [RESULT_SLOTS];
   offset_type  s3_cur_in [RESULT_SLOTS];

   result_type  buf_ff [RESULT_SLOTS];
   result_type  buf_in [RESULT_SLOTS];
   logic [RESULT_SLOTS-1:0] mask_ff, mask_in;

   logic        s1_ready, s2_ready, s3_ready, buf_ready, buf_load;
   logic [RANK_BITS-1:0] rank [RANGE_COUNT];
   logic        cap_fail;
   logic [SLOT_BITS-1:0] sel;
   logic [RESULT_SLOTS-1:0] sel_onehot;
   logic        v_range [RANGE_COUNT];
   result_type  entry [RESULT_SLOTS];
   logic [RESULT_SLOTS-1:0] present;

   // Configuration registers.
   always_comb begin
      cap_in = cap_ff;
      for (int i = 0; i < RANGE_COUNT; i++) begin
         range_in[i] = range_ff[i];
      end
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEVICE_CAPACITY: cap_in         = csr_wdata;
            CSR_RANGE0_BEGIN:    range_in[0].lo = csr_wdata;
            CSR_RANGE0_END:      range_in[0].hi = csr_wdata;
            CSR_RANGE1_BEGIN:    range_in[1].lo = csr_wdata;
            CSR_RANGE1_END:      range_in[1].hi = csr_wdata;
            CSR_RANGE2_BEGIN:    range_in[2].lo = csr_wdata;
            CSR_RANGE2_END:      range_in[2].hi = csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Handshake chain.
   assign buf_ready = (mask_ff == '0) || (rsp_ready && rsp_last_result);
   assign buf_load  = s3_valid_ff && buf_ready;
   assign s3_ready  = !s3_valid_ff || buf_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   // Stage one: input register.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_offset_in = s1_offset_ff;
      s1_length_in = s1_length_ff;
      s1_cancel_in = s1_cancel_ff;
      if (s1_ready) begin
         s1_valid_in  = req_valid;
         s1_offset_in = req_write_offset;
         s1_length_in = req_write_length;
         s1_cancel_in = req_cancel_requested;
      end
   end

   // Stage two: checks, write end and ranges sorted by begin.
   always_comb begin
      cap_fail = (s1_offset_ff > cap_ff) ||
                 (OFFSET_BITS'(s1_length_ff) > (cap_ff - s1_offset_ff));
      for (int i = 0; i < RANGE_COUNT; i++) begin
         rank[i] = '0;
         for (int j = 0; j < RANGE_COUNT; j++) begin
            if (j < i) begin
               if (range_ff[j].lo <= range_ff[i].lo) rank[i] = rank[i] + 1'b1;
            end else if (j > i) begin
               if (range_ff[j].lo < range_ff[i].lo) rank[i] = rank[i] + 1'b1;
            end
         end
      end
      s2_valid_in  = s2_valid_ff;
      s2_status_in = s2_status_ff;
      s2_offset_in = s2_offset_ff;
      s2_wend_in   = s2_wend_ff;
      for (int k = 0; k < RANGE_COUNT; k++) begin
         s2_range_in[k] = s2_range_ff[k];
         s2_live_in[k]  = s2_live_ff[k];
      end
      if (s2_ready) begin
         s2_valid_in  = s1_valid_ff;
         s2_offset_in = s1_offset_ff;
         s2_wend_in   = s1_offset_ff + OFFSET_BITS'(s1_length_ff);
         if (s1_cancel_ff) begin
            s2_status_in = STATUS_CANCELLED;
         end else if (cap_fail) begin
            s2_status_in = STATUS_CAPACITY;
         end else begin
            s2_status_in = STATUS_SEGMENT;
         end
         for (int k = 0; k < RANGE_COUNT; k++) begin
            for (int i = 0; i < RANGE_COUNT; i++) begin
               if (rank[i] == RANK_BITS'(k)) begin
                  s2_range_in[k] = range_ff[i];
                  s2_live_in[k]  = (i < NUM_RANGES) && (range_ff[i].hi > range_ff[i].lo);
               end
            end
         end
      end
   end

   // Stage three: the write cursor before each range and after the last.
   always_comb begin
      for (int i = 0; i < RANGE_COUNT; i++) begin
         v_range[i] = s2_live_ff[i] && (s2_range_ff[i].lo < s2_wend_ff);
      end
      s3_valid_in  = s3_valid_ff;
      s3_status_in = s3_status_ff;
      s3_offset_in = s3_offset_ff;
      s3_wend_in   = s3_wend_ff;
      for (int i = 0; i < RANGE_COUNT; i++) begin
         s3_lo_in[i]  = s3_lo_ff[i];
         s3_use_in[i] = s3_use_ff[i];
      end
      for (int i = 0; i < RESULT_SLOTS; i++) begin
         s3_cur_in[i] = s3_cur_ff[i];
      end
      if (s3_ready) begin
         s3_valid_in  = s2_valid_ff;
         s3_status_in = s2_status_ff;
         s3_offset_in = s2_offset_ff;
         s3_wend_in   = s2_wend_ff;
         s3_cur_in[0] = s2_offset_ff;
         for (int i = 0; i < RANGE_COUNT; i++) begin
            s3_lo_in[i]  = s2_range_ff[i].lo;
            s3_use_in[i] = v_range[i];
            if (v_range[i] && (s2_range_ff[i].hi > s3_cur_in[i])) begin
               s3_cur_in[i+1] = s2_range_ff[i].hi;
            end else begin
               s3_cur_in[i+1] = s3_cur_in[i];
            end
         end
      end
   end

   // Result buffer: up to one segment before each range and one after the last, or one status beat.
   always_comb begin
      for (int i = 0; i < RANGE_COUNT; i++) begin
         entry[i].seg_offset = s3_cur_ff[i];
         entry[i].seg_length = LENGTH_BITS'(s3_lo_ff[i] - s3_cur_ff[i]);
         entry[i].pay_offset = LENGTH_BITS'(s3_cur_ff[i] - s3_offset_ff);
         entry[i].status     = STATUS_SEGMENT;
         present[i]          = s3_use_ff[i] && (s3_lo_ff[i] > s3_cur_ff[i]);
      end
      entry[RANGE_COUNT].seg_offset = s3_cur_ff[RANGE_COUNT];
      entry[RANGE_COUNT].seg_length = LENGTH_BITS'(s3_wend_ff - s3_cur_ff[RANGE_COUNT]);
      entry[RANGE_COUNT].pay_offset = LENGTH_BITS'(s3_cur_ff[RANGE_COUNT] - s3_offset_ff);
      entry[RANGE_COUNT].status     = STATUS_SEGMENT;
      present[RANGE_COUNT]          = s3_cur_ff[RANGE_COUNT] < s3_wend_ff;
      if ((s3_status_ff != STATUS_SEGMENT) || (present == '0)) begin
         entry[0].seg_offset = s3_offset_ff;
         entry[0].seg_length = '0;
         entry[0].pay_offset = '0;
         entry[0].status     = (s3_status_ff == STATUS_SEGMENT) ? STATUS_NONE : s3_status_ff;
         present             = RESULT_SLOTS'(1);
      end

      for (int i = 0; i < RESULT_SLOTS; i++) begin
         buf_in[i] = buf_ff[i];
      end
      mask_in = mask_ff;
      if (buf_load) begin
         for (int i = 0; i < RESULT_SLOTS; i++) begin
            buf_in[i] = entry[i];
         end
         mask_in = present;
      end else if (rsp_valid && rsp_ready) begin
         mask_in = mask_ff & ~sel_onehot;
      end
   end

   // Output selection: the lowest pending slot goes out first.
   always_comb begin
      sel        = '0;
      sel_onehot = '0;
      for (int i = RESULT_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel        = SLOT_BITS'(i);
            sel_onehot = RESULT_SLOTS'(1) << i;
         end
      end
   end

   assign rsp_valid          = (mask_ff != '0);
   assign rsp_segment_offset = buf_ff[sel].seg_offset;
   assign rsp_segment_length = buf_ff[sel].seg_length;
   assign rsp_data_offset    = buf_ff[sel].pay_offset;
   assign rsp_status         = buf_ff[sel].status;
   assign rsp_last_result    = ((mask_ff & ~sel_onehot) == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= '0;
         for (int i = 0; i < RANGE_COUNT; i++) begin
            range_ff[i] <= '0;
         end
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         mask_ff     <= '0;
      end else begin
         cap_ff      <= cap_in;
         for (int i = 0; i < RANGE_COUNT; i++) begin
            range_ff[i] <= range_in[i];
         end
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         mask_ff     <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_offset_ff <= s1_offset_in;
      s1_length_ff <= s1_length_in;
      s1_cancel_ff <= s1_cancel_in;
      s2_status_ff <= s2_status_in;
      s2_offset_ff <= s2_offset_in;
      s2_wend_ff   <= s2_wend_in;
      s3_status_ff <= s3_status_in;
      s3_offset_ff <= s3_offset_in;
      s3_wend_ff   <= s3_wend_in;
      for (int i = 0; i < RANGE_COUNT; i++) begin
         s2_range_ff[i] <= s2_range_in[i];
         s2_live_ff[i]  <= s2_live_in[i];
         s3_lo_ff[i]    <= s3_lo_in[i];
         s3_use_ff[i]   <= s3_use_in[i];
      end
      for (int i = 0; i < RESULT_SLOTS; i++) begin
         s3_cur_ff[i] <= s3_cur_in[i];
         buf_ff[i]    <= buf_in[i];
      end
   end

   `PRW_ASSERT_IMPLY(a_status_is_last, rsp_valid && (rsp_status != STATUS_SEGMENT), rsp_last_result, "status beat is not the last of its request")
   `PRW_ASSERT_IMPLY(a_segment_not_empty, rsp_valid && (rsp_status == STATUS_SEGMENT), rsp_segment_length != '0, "segment beat with zero length")
   `PRW_ASSERT_NEXT(a_pending_held, rsp_valid && !rsp_ready, $stable(mask_ff), "pending results changed while stalled")
   `PRW_ASSERT_IMPLY(a_load_when_free, buf_load, (mask_ff == '0) || (rsp_ready && $onehot(mask_ff)), "result buffer overwritten")

endmodule

`default_nettype wire

/* bench/tb_protected_range_write_splitter_top.sv */
`timescale 1ns / 100ps

module tb_protected_range_write_splitter_top;
   import prw_pkg::*;

   localparam offset_type OFFSET_MAX = '1;
   localparam length_type LENGTH_MAX = '1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int PHASE_COUNT = 8;
   localparam int REQUESTS_PER_PHASE = 56;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PERCENT = 21;

   localparam csr_index_type BEGIN_REG [RANGE_COUNT] =
      '{CSR_RANGE0_BEGIN, CSR_RANGE1_BEGIN, CSR_RANGE2_BEGIN};
   localparam csr_index_type END_REG [RANGE_COUNT] =
      '{CSR_RANGE0_END, CSR_RANGE1_END, CSR_RANGE2_END};

   typedef enum logic {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [CSR_INDEX_BITS-1:0] index;
      offset_type offset;
      length_type length;
      logic cancel;
      logic typed;
      status_type status;
   } stim_row_type;

   typedef struct packed {
      offset_type seg_offset;
      length_type seg_length;
      length_type pay_offset;
      status_type status;
      logic last;
   } result_beat_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   offset_type req_write_offset = '0;
   length_type req_write_length = '0;
   logic req_cancel_requested = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   offset_type rsp_segment_offset;
   length_type rsp_segment_length;
   length_type rsp_data_offset;
   logic [1:0] rsp_status;
   logic rsp_last_result;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   offset_type csr_wdata = '0;

   offset_type capacity_reg;
   offset_type range_begin [RANGE_COUNT];
   offset_type range_end [RANGE_COUNT];
   result_beat_type pending_results [$];
   stim_row_type directed_rows [$];
   int error_count = 0;
   int cycle_count = 0;
   bit steady = 1'b0;

   protected_range_write_splitter_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_write_offset(req_write_offset),
      .req_write_length(req_write_length),
      .req_cancel_requested(req_cancel_requested),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_segment_offset(rsp_segment_offset),
      .rsp_segment_length(rsp_segment_length),
      .rsp_data_offset(rsp_data_offset),
      .rsp_status(rsp_status),
      .rsp_last_result(rsp_last_result),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic offset_type rand48();
      return offset_type'({$urandom(), $urandom()});
   endfunction

   function automatic offset_type pick(input offset_type lo, input offset_type hi);
      offset_type span;
      if (hi <= lo) begin
         return lo;
      end
      span = hi - lo;
      if (span == OFFSET_MAX) begin
         return rand48();
      end
      return lo + rand48() % (span + 1);
   endfunction

   function automatic void push_status(input offset_type off, input status_type st);
      result_beat_type beat;
      beat.seg_offset = off;
      beat.seg_length = '0;
      beat.pay_offset = '0;
      beat.status = st;
      beat.last = 1'b1;
      pending_results.push_back(beat);
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_BITS-1:0] idx, input offset_type data);
      case (idx)
         CSR_DEVICE_CAPACITY: capacity_reg = data;
         CSR_RANGE0_BEGIN: range_begin[0] = data;
         CSR_RANGE0_END: range_end[0] = data;
         CSR_RANGE1_BEGIN: range_begin[1] = data;
         CSR_RANGE1_END: range_end[1] = data;
         CSR_RANGE2_BEGIN: range_begin[2] = data;
         CSR_RANGE2_END: range_end[2] = data;
         default: ;
      endcase
   endfunction

   // Ranges are visited in ascending order of begin and the cursor only ever moves forward,
   // so overlapping ranges merge naturally.
   function automatic void split_write(input offset_type off, input length_type len,
                                       input logic cancel);
      offset_type tail, cursor, b, e;
      int order [RANGE_COUNT];
      int i, j, t;
      bit done;
      result_beat_type beat;
      result_beat_type pieces [$];
      if (cancel) begin
         push_status(off, STATUS_CANCELLED);
         return;
      end
      if (off > capacity_reg || offset_type'(len) > capacity_reg - off) begin
         push_status(off, STATUS_CAPACITY);
         return;
      end
      if (len == '0) begin
         push_status(off, STATUS_NONE);
         return;
      end
      tail = off + offset_type'(len);
      cursor = off;
      done = 1'b0;
      for (i = 0; i < RANGE_COUNT; i++) begin
         order[i] = i;
      end
      for (i = 1; i < NUM_RANGES; i++) begin
         t = order[i];
         j = i - 1;
         while (j >= 0 && range_begin[order[j]] > range_begin[t]) begin
            order[j + 1] = order[j];
            j--;
         end
         order[j + 1] = t;
      end
      for (i = 0; i < NUM_RANGES && !done; i++) begin
         b = range_begin[order[i]];
         e = range_end[order[i]];
         if (e <= b || e <= cursor || b >= tail) begin
            continue;
         end
         if (b > cursor) begin
            beat.seg_offset = cursor;
            beat.seg_length = length_type'(b - cursor);
            beat.pay_offset = length_type'(cursor - off);
            beat.status = STATUS_SEGMENT;
            beat.last = 1'b0;
            pieces.push_back(beat);
         end
         if (e > cursor) begin
            cursor = e;
         end
         if (cursor >= tail) begin
            done = 1'b1;
         end
      end
      if (!done && cursor < tail) begin
         beat.seg_offset = cursor;
         beat.seg_length = length_type'(tail - cursor);
         beat.pay_offset = length_type'(cursor - off);
         beat.status = STATUS_SEGMENT;
         beat.last = 1'b0;
         pieces.push_back(beat);
      end
      if (pieces.size() == 0) begin
         push_status(off, STATUS_NONE);
         return;
      end
      for (i = 0; i < pieces.size(); i++) begin
         beat = pieces[i];
         beat.last = (i == pieces.size() - 1);
         pending_results.push_back(beat);
      end
   endfunction

   function automatic stim_row_type make_req(input offset_type off, input length_type len,
                                             input logic cancel);
      stim_row_type row;
      row.kind = ROW_REQUEST;
      row.index = '0;
      row.offset = off;
      row.length = len;
      row.cancel = cancel;
      row.typed = 1'b0;
      row.status = STATUS_SEGMENT;
      return row;
   endfunction

   function automatic stim_row_type make_status(input offset_type off, input length_type len,
                                                input logic cancel, input status_type st);
      stim_row_type row;
      row = make_req(off, len, cancel);
      row.typed = 1'b1;
      row.status = st;
      return row;
   endfunction

   function automatic stim_row_type make_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                             input offset_type data);
      stim_row_type row;
      row = make_req(data, '0, 1'b0);
      row.kind = ROW_CSR;
      row.index = idx;
      return row;
   endfunction

   task automatic send_request(input stim_row_type row);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_write_offset <= row.offset;
      req_write_length <= row.length;
      req_cancel_requested <= row.cancel;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      if (row.typed) begin
         push_status(row.offset, row.status);
      end else begin
         split_write(row.offset, row.length, row.cancel);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input offset_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      apply_csr(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin : check_results
      result_beat_type want;
      result_beat_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.seg_offset = rsp_segment_offset;
         got.seg_length = rsp_segment_length;
         got.pay_offset = rsp_data_offset;
         got.status = status_type'(rsp_status);
         got.last = rsp_last_result;
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing expected: offset %h length %h payload %h",
                     $time, got.seg_offset, got.seg_length, got.pay_offset);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               $display("%0t: expected offset %h length %h payload %h status %0d last %b",
                        $time, want.seg_offset, want.seg_length, want.pay_offset,
                        want.status, want.last);
               $display("%0t: actual   offset %h length %h payload %h status %0d last %b",
                        $time, got.seg_offset, got.seg_length, got.pay_offset,
                        got.status, got.last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("protected_range_write_splitter_top test failed");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type row;
      offset_type base, span, cap, b, e, off, room;
      length_type len_max, len;
      int phase, r, k, roll;
      capacity_reg = '0;
      for (r = 0; r < RANGE_COUNT; r++) begin
         range_begin[r] = '0;
         range_end[r] = '0;
      end

      directed_rows.push_back(make_status('0, '0, 1'b0, STATUS_NONE));
      directed_rows.push_back(make_status('0, 32'd1, 1'b0, STATUS_CAPACITY));
      directed_rows.push_back(make_status(OFFSET_MAX, LENGTH_MAX, 1'b1, STATUS_CANCELLED));
      directed_rows.push_back(make_status(48'd1, '0, 1'b0, STATUS_CAPACITY));
      directed_rows.push_back(make_csr(CSR_DEVICE_CAPACITY, OFFSET_MAX));
      directed_rows.push_back(make_status(OFFSET_MAX, LENGTH_MAX, 1'b0, STATUS_CAPACITY));
      directed_rows.push_back(make_status(OFFSET_MAX, '0, 1'b0, STATUS_NONE));
      directed_rows.push_back(make_req('0, LENGTH_MAX, 1'b0));
      directed_rows.push_back(make_req(OFFSET_MAX - offset_type'(LENGTH_MAX), LENGTH_MAX, 1'b0));
      directed_rows.push_back(make_csr(CSR_RANGE0_BEGIN, 48'd100));
      directed_rows.push_back(make_csr(CSR_RANGE0_END, 48'd200));
      directed_rows.push_back(make_csr(CSR_RANGE1_BEGIN, 48'd150));
      directed_rows.push_back(make_csr(CSR_RANGE1_END, 48'd300));
      directed_rows.push_back(make_csr(CSR_RANGE2_BEGIN, 48'd50));
      directed_rows.push_back(make_csr(CSR_RANGE2_END, 48'd60));
      directed_rows.push_back(make_req('0, 32'd1000, 1'b0));
      directed_rows.push_back(make_status(48'd100, 32'd200, 1'b0, STATUS_NONE));
      directed_rows.push_back(make_status(48'd120, 32'd10, 1'b0, STATUS_NONE));
      directed_rows.push_back(make_req(48'd40, 32'd30, 1'b0));
      directed_rows.push_back(make_req(48'd299, 32'd2, 1'b0));
      directed_rows.push_back(make_csr(CSR_RANGE1_BEGIN, 48'd400));
      directed_rows.push_back(make_csr(CSR_RANGE1_END, 48'd500));
      directed_rows.push_back(make_req('0, 32'd1000, 1'b0));
      directed_rows.push_back(make_csr(CSR_RANGE2_BEGIN, 48'd100));
      directed_rows.push_back(make_csr(CSR_RANGE2_END, 48'd150));
      directed_rows.push_back(make_req(48'd90, 32'd20, 1'b0));
      directed_rows.push_back(make_csr(CSR_RANGE0_END, 48'd100));
      directed_rows.push_back(make_req(48'd90, 32'd70, 1'b0));
      directed_rows.push_back(make_csr(CSR_UNUSED_INDEX, 48'h1234));
      directed_rows.push_back(make_req('0, 32'd600, 1'b0));
      directed_rows.push_back(make_csr(CSR_RANGE0_BEGIN, OFFSET_MAX - 48'd10));
      directed_rows.push_back(make_csr(CSR_RANGE0_END, OFFSET_MAX));
      directed_rows.push_back(make_csr(CSR_RANGE1_END, '0));
      directed_rows.push_back(make_req(OFFSET_MAX - 48'd20, 32'd20, 1'b0));
      directed_rows.push_back(make_status(OFFSET_MAX - 48'd20, 32'd20, 1'b1, STATUS_CANCELLED));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_csr(directed_rows[i].index, directed_rows[i].offset);
         end else begin
            send_request(directed_rows[i]);
         end
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         steady = (phase == 5);
         case (phase % 4)
            0: begin
               span = offset_type'($urandom_range(200, 5000));
               base = '0;
               cap = span;
            end
            1: begin
               span = offset_type'($urandom_range(200, 5000));
               base = OFFSET_MAX - span;
               cap = OFFSET_MAX;
            end
            2: begin
               span = pick(48'h1_0000_0000, 48'h4_0000_0000);
               base = pick('0, OFFSET_MAX >> 1);
               cap = ($urandom_range(0, 1) == 0) ? OFFSET_MAX : base + span;
            end
            default: begin
               span = offset_type'($urandom_range(200, 5000));
               base = pick('0, OFFSET_MAX - 2 * span);
               cap = base + pick('0, span);
            end
         endcase

         wait_idle();
         write_csr(CSR_DEVICE_CAPACITY, cap);
         for (r = 0; r < RANGE_COUNT; r++) begin
            b = base + pick('0, span);
            if ($urandom_range(0, 99) < 20) begin
               e = b - pick('0, (b < span / 4) ? b : span / 4);
            end else begin
               room = pick(48'd1, span / 3);
               e = (OFFSET_MAX - b < room) ? OFFSET_MAX : b + room;
            end
            write_csr(BEGIN_REG[r], b);
            write_csr(END_REG[r], e);
         end

         for (k = 0; k < REQUESTS_PER_PHASE; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
               row = make_req(rand48(), $urandom(), 1'b1);
            end else if (roll < 12) begin
               off = ($urandom_range(0, 1) == 0) ? rand48() : pick(base, base + span);
               row = make_req(off, $urandom(), 1'b0);
            end else begin
               off = pick(base, base + span);
               room = (off > cap) ? '0 : cap - off;
               len_max = (room > offset_type'(LENGTH_MAX)) ? LENGTH_MAX : length_type'(room);
               roll = $urandom_range(0, 99);
               if (roll < 8 && len_max != LENGTH_MAX) begin
                  len = len_max + 1;
               end else if (roll < 16) begin
                  len = len_max;
               end else if (roll < 22) begin
                  len = '0;
               end else begin
                  len = length_type'(pick('0, offset_type'(len_max)));
               end
               row = make_req(off, len, 1'b0);
            end
            send_request(row);
         end
      end

      steady = 1'b0;
      wait_idle();
      if (error_count == 0) begin
         $display("protected_range_write_splitter_top test passed");
      end else begin
         $display("protected_range_write_splitter_top test failed");
      end
      $finish;
   end

endmodule

/* protected_range_write_splitter_top.f */
+incdir+sv
sv/prw_pkg.sv
sv/protected_range_write_splitter_top.sv
bench/tb_protected_range_write_splitter_top.sv
